// ----- src/mlse_pkg.sv -----
// shared types and opcode constants for the misaligned load/store emulator
package mlse_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_UNSUPPORTED = 2'd1,
		ST_FAULT       = 2'd2
	} status_t;

	// access sizes in bytes
	localparam logic [3:0] SIZE_NONE = 4'd0;
	localparam logic [3:0] SIZE_H    = 4'd2;
	localparam logic [3:0] SIZE_W    = 4'd4;
	localparam logic [3:0] SIZE_D    = 4'd8;

	// decoded access descriptor
	typedef struct packed {
		logic       valid;
		logic       store;
		logic       is_float;
		logic [3:0] size;
		logic [4:0] rd;
		logic       sign;
	} access_desc_t;

	// opcode field at bits 31:22
	localparam logic [9:0] A_LD_D  = 10'h0a3;
	localparam logic [9:0] A_LD_W  = 10'h0a2;
	localparam logic [9:0] A_LD_WU = 10'h0aa;
	localparam logic [9:0] A_LD_H  = 10'h0a1;
	localparam logic [9:0] A_LD_HU = 10'h0a9;
	localparam logic [9:0] A_ST_D  = 10'h0a7;
	localparam logic [9:0] A_ST_W  = 10'h0a6;
	localparam logic [9:0] A_ST_H  = 10'h0a5;
	localparam logic [9:0] A_FLD_D = 10'h0ae;
	localparam logic [9:0] A_FLD_S = 10'h0ac;
	localparam logic [9:0] A_FST_D = 10'h0af;
	localparam logic [9:0] A_FST_S = 10'h0ad;

	// opcode field at bits 31:24
	localparam logic [7:0] B_LDPTR_D = 8'h26;
	localparam logic [7:0] B_LDPTR_W = 8'h24;
	localparam logic [7:0] B_STPTR_D = 8'h27;
	localparam logic [7:0] B_STPTR_W = 8'h25;

	// opcode field at bits 31:15
	localparam logic [16:0] C_LDX_D  = 17'h07018;
	localparam logic [16:0] C_LDX_W  = 17'h07010;
	localparam logic [16:0] C_LDX_WU = 17'h07050;
	localparam logic [16:0] C_LDX_H  = 17'h07008;
	localparam logic [16:0] C_LDX_HU = 17'h07048;
	localparam logic [16:0] C_STX_D  = 17'h07038;
	localparam logic [16:0] C_STX_W  = 17'h07030;
	localparam logic [16:0] C_STX_H  = 17'h07028;
	localparam logic [16:0] C_FLDX_D = 17'h07068;
	localparam logic [16:0] C_FLDX_S = 17'h07060;
	localparam logic [16:0] C_FSTX_D = 17'h07078;
	localparam logic [16:0] C_FSTX_S = 17'h07070;

endpackage

// ----- src/mlse_decode.sv -----
// opcode decoder: instruction word to access descriptor
module mlse_decode (
	input  logic [31:0]                 instr_word,
	output mlse_pkg::access_desc_t      desc
);

	logic [9:0]  opa;
	logic [7:0]  opb;
	logic [16:0] opc;

	assign opa = instr_word[31:22];
	assign opb = instr_word[31:24];
	assign opc = instr_word[31:15];

	always_comb begin
		desc          = '0;
		desc.rd       = instr_word[4:0];
		desc.valid    = 1'b1;
		if (opa == mlse_pkg::A_LD_D || opb == mlse_pkg::B_LDPTR_D ||
				opc == mlse_pkg::C_LDX_D) begin
			desc.size = mlse_pkg::SIZE_D;
			desc.sign = 1'b1;
		end else if (opa == mlse_pkg::A_LD_W || opb == mlse_pkg::B_LDPTR_W ||
				opc == mlse_pkg::C_LDX_W) begin
			desc.size = mlse_pkg::SIZE_W;
			desc.sign = 1'b1;
		end else if (opa == mlse_pkg::A_LD_WU || opc == mlse_pkg::C_LDX_WU) begin
			desc.size = mlse_pkg::SIZE_W;
		end else if (opa == mlse_pkg::A_LD_H || opc == mlse_pkg::C_LDX_H) begin
			desc.size = mlse_pkg::SIZE_H;
			desc.sign = 1'b1;
		end else if (opa == mlse_pkg::A_LD_HU || opc == mlse_pkg::C_LDX_HU) begin
			desc.size = mlse_pkg::SIZE_H;
		end else if (opa == mlse_pkg::A_ST_D || opb == mlse_pkg::B_STPTR_D ||
				opc == mlse_pkg::C_STX_D) begin
			desc.store = 1'b1;
			desc.size  = mlse_pkg::SIZE_D;
		end else if (opa == mlse_pkg::A_ST_W || opb == mlse_pkg::B_STPTR_W ||
				opc == mlse_pkg::C_STX_W) begin
			desc.store = 1'b1;
			desc.size  = mlse_pkg::SIZE_W;
		end else if (opa == mlse_pkg::A_ST_H || opc == mlse_pkg::C_STX_H) begin
			desc.store = 1'b1;
			desc.size  = mlse_pkg::SIZE_H;
		end else if (opa == mlse_pkg::A_FLD_D || opc == mlse_pkg::C_FLDX_D) begin
			desc.is_float = 1'b1;
			desc.size     = mlse_pkg::SIZE_D;
		end else if (opa == mlse_pkg::A_FLD_S || opc == mlse_pkg::C_FLDX_S) begin
			desc.is_float = 1'b1;
			desc.size     = mlse_pkg::SIZE_W;
			desc.sign     = 1'b1;
		end else if (opa == mlse_pkg::A_FST_D || opc == mlse_pkg::C_FSTX_D) begin
			desc.store    = 1'b1;
			desc.is_float = 1'b1;
			desc.size     = mlse_pkg::SIZE_D;
		end else if (opa == mlse_pkg::A_FST_S || opc == mlse_pkg::C_FSTX_S) begin
			desc.store    = 1'b1;
			desc.is_float = 1'b1;
			desc.size     = mlse_pkg::SIZE_W;
		end else begin
			desc.valid = 1'b0;
		end
	end

endmodule

// ----- src/misaligned_load_store_emulator.sv -----
// top level of the misaligned load/store emulator
// usage:
//   the request channel (in_valid/in_stall) carries one trapping load or store:
//   instruction word, access address, raw little-endian load bytes and a fault flag
//   the result channel (out_valid/out_stall) returns status, direction, access size,
//   the echoed address and store data for each request, in order
//   a request is taken into an input register; there it is decoded, the
//   load data is masked and sign-extended, and when it advances the target
//   register is written and the result is captured in the output register
//   each result passes the input register, then the output register, before out_valid
//   throughput: one request per cycle while out_stall is low; the decode, mask
//   and register file access all sit between the input register and the output register
//   when the receiver stalls the result holds, one more request may wait in the
//   input register, then in_stall rises until the output drains
//   reset clears both stages, all register files, the program counter and the
//   vector-lane enable
//   the apb port holds one register at address 0: bit 0 enables vector low-lane
//   updates on floating-point loads; write it only while the block is idle
module misaligned_load_store_emulator (
	input  logic        clk,
	input  logic        arst_n,

	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	input  logic [63:0] access_addr,
	input  logic [63:0] load_bytes,
	input  logic        mem_fault,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        is_store,
	output logic [3:0]  access_size,
	output logic [63:0] mem_addr,
	output logic [63:0] store_value,

	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// stage 1: input register
	logic        valid_s1;
	logic [31:0] instr_word_s1;
	logic [63:0] access_addr_s1;
	logic [63:0] load_bytes_s1;
	logic        mem_fault_s1;

	// stage 2: result register
	logic              valid_s2;
	mlse_pkg::status_t status_s2;
	logic              is_store_s2;
	logic [3:0]        access_size_s2;
	logic [63:0]       mem_addr_s2;
	logic [63:0]       store_value_s2;

	// architectural state
	logic [63:0] gpr_q [1:31];
	logic [63:0] fpr_q [32];
	logic [63:0] vlane_q [32];
	logic [63:0] pc_q;
	logic        vec_en_q;

	mlse_pkg::access_desc_t desc;
	mlse_pkg::status_t      status_c;
	logic                   accept;
	logic                   advance;
	logic                   done;
	logic                   do_load;
	logic [63:0]            load_val;
	logic [63:0]            gpr_rd;
	logic [63:0]            store_val;
	logic                   cfg_wr;

	// handshake: stage 1 moves on whenever the output register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign accept   = in_valid && !in_stall;

	mlse_decode u_decode (
		.instr_word (instr_word_s1),
		.desc       (desc)
	);

	// a good decode without a fault completes and touches state
	assign done    = desc.valid && !mem_fault_s1;
	assign do_load = done && !desc.store;

	// mask to access size, sign-extend where the opcode asks for it
	always_comb begin
		case (desc.size)
			mlse_pkg::SIZE_H:
				load_val = {{48{desc.sign & load_bytes_s1[15]}}, load_bytes_s1[15:0]};
			mlse_pkg::SIZE_W:
				load_val = {{32{desc.sign & load_bytes_s1[31]}}, load_bytes_s1[31:0]};
			default:
				load_val = load_bytes_s1;
		endcase
	end

	// register 0 of the general file reads as zero
	assign gpr_rd = (desc.rd == 5'd0) ? 64'd0 : gpr_q[desc.rd];

	always_comb begin
		store_val = 64'd0;
		if (done && desc.store) begin
			store_val = desc.is_float ? fpr_q[desc.rd] : gpr_rd;
		end
	end

	always_comb begin
		if (!desc.valid) begin
			status_c = mlse_pkg::ST_UNSUPPORTED;
		end else if (mem_fault_s1) begin
			status_c = mlse_pkg::ST_FAULT;
		end else begin
			status_c = mlse_pkg::ST_OK;
		end
	end

	// control for both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_word_s1  <= instr_word;
			access_addr_s1 <= access_addr;
			load_bytes_s1  <= load_bytes;
			mem_fault_s1   <= mem_fault;
		end
	end

	// result payload; unsupported opcodes report no direction or size
	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2      <= status_c;
			is_store_s2    <= desc.valid && desc.store;
			access_size_s2 <= desc.valid ? desc.size : mlse_pkg::SIZE_NONE;
			mem_addr_s2    <= access_addr_s1;
			store_value_s2 <= store_val;
		end
	end

	// general register file, writes to register 0 dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i < 32; i++) begin
				gpr_q[i] <= 64'd0;
			end
		end else if (advance && do_load && !desc.is_float && desc.rd != 5'd0) begin
			gpr_q[desc.rd] <= load_val;
		end
	end

	// floating-point file and vector low lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) begin
				fpr_q[i]   <= 64'd0;
				vlane_q[i] <= 64'd0;
			end
		end else if (advance && do_load && desc.is_float) begin
			fpr_q[desc.rd] <= load_val;
			if (vec_en_q) begin
				vlane_q[desc.rd] <= load_val;
			end
		end
	end

	// program counter steps past each completed access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 64'd0;
		end else if (advance && done) begin
			pc_q <= pc_q + 64'd4;
		end
	end

	// configuration register
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_en_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == 1'b0) begin
			vec_en_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, vec_en_q} : 32'd0;

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign is_store    = is_store_s2;
	assign access_size = access_size_s2;
	assign mem_addr    = mem_addr_s2;
	assign store_value = store_value_s2;

endmodule
